// ===== rtl/assert_macros.svh =====
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked at every rising edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/wbps_pkg.sv =====
package wbps_pkg;

   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 64;
   localparam int CARE_W       = 16;
   localparam int LENGTH_W     = 5;
   localparam int PATTERN_REGS = 16;
   localparam int OFFSET_OUT_W = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_LOW  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_HIGH = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CARE_MASK    = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_LENGTH       = 2'd3;

   localparam logic [CARE_W-1:0]   CARE_MASK_RESET = 16'hFFFF;
   localparam logic [LENGTH_W-1:0] LENGTH_RESET    = 5'd1;

   typedef struct packed {
      logic [63:0]         pattern_low_bytes;
      logic [63:0]         pattern_high_bytes;
      logic [CARE_W-1:0]   care_mask;
      logic [LENGTH_W-1:0] pattern_length;
   } cfg_type;

   typedef struct packed {
      logic                    found;
      logic [OFFSET_OUT_W-1:0] match_offset;
   } result_type;

endpackage

// ===== rtl/wildcard_byte_pattern_scan.sv =====
// a result appears on rsp_ in the cycle after the byte that causes it is taken
// throughput: one byte per cycle while req_stall is low, set by the combinational masked window compare
// req_stall is high only while a finished result waits and rsp_stall is high
// reset (synchronous, active high) clears the byte count, the match flag and output valid
// and loads the register defaults: pattern zero, care mask all ones, length one
module wildcard_byte_pattern_scan #(
   parameter int PATTERN_MAX  = 16,
   parameter int OFFSET_WIDTH = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [7:0]                           req_data_byte,
   input  logic                                 req_last_byte,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_found,
   output logic [wbps_pkg::OFFSET_OUT_W-1:0]    rsp_match_offset,
   input  logic                                 csr_write_enable,
   input  logic [wbps_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [wbps_pkg::CSR_DATA_W-1:0]      csr_write_data
);
   import wbps_pkg::*;

   cfg_type    cfg;
   result_type res;
   logic       res_valid;
   logic       take;

   assign take = req_valid && !req_stall;

   wbps_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   wbps_scan #(
      .PATTERN_MAX  (PATTERN_MAX),
      .OFFSET_WIDTH (OFFSET_WIDTH)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .take      (take),
      .data_byte (req_data_byte),
      .last_byte (req_last_byte),
      .res_valid (res_valid),
      .res       (res)
   );

   wbps_rsp_reg u_rsp (
      .clock            (clock),
      .reset            (reset),
      .load             (res_valid),
      .data             (res),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_found        (rsp_found),
      .rsp_match_offset (rsp_match_offset),
      .busy             (req_stall)
   );

endmodule

// ===== rtl/wbps_csr.sv =====
module wbps_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [wbps_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [wbps_pkg::CSR_DATA_W-1:0]     csr_write_data,
   output wbps_pkg::cfg_type                   cfg
);
   import wbps_pkg::*;

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pattern_low_bytes  <= '0;
         cfg_ff.pattern_high_bytes <= '0;
         cfg_ff.care_mask          <= CARE_MASK_RESET;
         cfg_ff.pattern_length     <= LENGTH_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_PATTERN_LOW:  cfg_ff.pattern_low_bytes  <= csr_write_data;
            CSR_PATTERN_HIGH: cfg_ff.pattern_high_bytes <= csr_write_data;
            CSR_CARE_MASK:    cfg_ff.care_mask          <= csr_write_data[CARE_W-1:0];
            CSR_LENGTH:       cfg_ff.pattern_length     <= csr_write_data[LENGTH_W-1:0];
            default:          cfg_ff.pattern_length     <= cfg_ff.pattern_length;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/wbps_scan.sv =====
module wbps_scan #(
   parameter int PATTERN_MAX  = 16,
   parameter int OFFSET_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  wbps_pkg::cfg_type      cfg,
   input  logic                   take,
   input  logic [7:0]             data_byte,
   input  logic                   last_byte,
   output logic                   res_valid,
   output wbps_pkg::result_type   res
);
   import wbps_pkg::*;

   localparam int IDX_W  = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
   localparam int ELEN_W = $clog2(PATTERN_MAX + 1);
   localparam int EXT_W  = (OFFSET_WIDTH > OFFSET_OUT_W) ? OFFSET_WIDTH : OFFSET_OUT_W;

   logic [7:0]              win_ff [PATTERN_MAX];
   logic [7:0]              win_in [PATTERN_MAX];
   logic [7:0]              shifted [PATTERN_MAX];
   logic [7:0]              pat_byte [PATTERN_MAX];
   logic                    pat_care [PATTERN_MAX];
   logic [OFFSET_WIDTH-1:0] seen_ff, seen_in, seen_inc, offset_w;
   logic [EXT_W-1:0]        offset_ext;
   logic                    reported_ff, reported_in;
   logic [ELEN_W-1:0]       eff_len;
   logic                    saturated, mismatch, hit;

   // pattern bytes past the sixteen held in registers are wildcards
   for (genvar g = 0; g < PATTERN_MAX; g++) begin : g_pat
      if (g < 8) begin : g_low
         assign pat_byte[g] = cfg.pattern_low_bytes[8*g +: 8];
         assign pat_care[g] = cfg.care_mask[g];
      end else if (g < PATTERN_REGS) begin : g_high
         assign pat_byte[g] = cfg.pattern_high_bytes[8*(g-8) +: 8];
         assign pat_care[g] = cfg.care_mask[g];
      end else begin : g_none
         assign pat_byte[g] = 8'd0;
         assign pat_care[g] = 1'b0;
      end
   end

   always_comb begin
      if (cfg.pattern_length == '0) begin
         eff_len = ELEN_W'(1);
      end else if (int'(cfg.pattern_length) > PATTERN_MAX) begin
         eff_len = ELEN_W'(PATTERN_MAX);
      end else begin
         eff_len = ELEN_W'(cfg.pattern_length);
      end
   end

   always_comb begin
      shifted[0] = data_byte;
      for (int k = 1; k < PATTERN_MAX; k++) begin
         shifted[k] = win_ff[k-1];
      end
   end

   // masked compare of the window that includes the new byte
   always_comb begin
      mismatch = 1'b0;
      for (int i = 0; i < PATTERN_MAX; i++) begin
         if (i < int'(eff_len)) begin
            if (pat_care[i] && shifted[IDX_W'(int'(eff_len) - 1 - i)] != pat_byte[i]) begin
               mismatch = 1'b1;
            end
         end
      end
   end

   assign saturated  = &seen_ff;
   assign seen_inc   = seen_ff + OFFSET_WIDTH'(1);
   assign hit        = !saturated && !mismatch && (seen_inc >= OFFSET_WIDTH'(eff_len));
   assign offset_w   = seen_inc - OFFSET_WIDTH'(eff_len);
   assign offset_ext = EXT_W'(offset_w);

   always_comb begin
      win_in           = win_ff;
      seen_in          = seen_ff;
      reported_in      = reported_ff;
      res_valid        = 1'b0;
      res.found        = 1'b0;
      res.match_offset = '0;
      if (take) begin
         if (reported_ff) begin
            if (last_byte) begin
               seen_in     = '0;
               reported_in = 1'b0;
            end
         end else begin
            if (!saturated) begin
               win_in  = shifted;
               seen_in = seen_inc;
            end
            if (hit) begin
               res_valid        = 1'b1;
               res.found        = 1'b1;
               res.match_offset = offset_ext[OFFSET_OUT_W-1:0];
               if (last_byte) begin
                  seen_in = '0;
               end else begin
                  reported_in = 1'b1;
               end
            end else if (last_byte) begin
               res_valid = 1'b1;
               seen_in   = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff     <= '0;
         reported_ff <= 1'b0;
      end else begin
         seen_ff     <= seen_in;
         reported_ff <= reported_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

endmodule

// ===== rtl/wbps_rsp_reg.sv =====
module wbps_rsp_reg (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 load,
   input  wbps_pkg::result_type                 data,
   input  logic                                 rsp_stall,
   output logic                                 rsp_valid,
   output logic                                 rsp_found,
   output logic [wbps_pkg::OFFSET_OUT_W-1:0]    rsp_match_offset,
   output logic                                 busy
);
   import wbps_pkg::*;

   logic       valid_ff;
   result_type data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data;
      end
   end

   assign busy             = valid_ff && rsp_stall;
   assign rsp_valid        = valid_ff;
   assign rsp_found        = data_ff.found;
   assign rsp_match_offset = data_ff.match_offset;

endmodule

// ===== rtl/wbps_checker.sv =====
`include "assert_macros.svh"

module wbps_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_found,
   input logic [31:0] rsp_match_offset
);

   `ASSERT_CLK(a_rsp_valid_holds, clock, reset, rsp_valid && rsp_stall |=> rsp_valid, "rsp_valid dropped while stalled")
   `ASSERT_CLK(a_rsp_payload_holds, clock, reset, rsp_valid && rsp_stall |=> $stable(rsp_found) && $stable(rsp_match_offset), "rsp payload changed while stalled")
   `ASSERT_CLK(a_not_found_zero, clock, reset, rsp_valid && !rsp_found |-> rsp_match_offset == 32'd0, "not-found result with nonzero offset")
   `ASSERT_CLK(a_stall_only_when_full, clock, reset, req_stall |-> rsp_valid && rsp_stall, "req_stall without a waiting result")
   `ASSERT_CLK(a_idle_after_reset, clock, reset, $past(reset) |-> !rsp_valid, "rsp_valid high right after reset")

endmodule

bind wildcard_byte_pattern_scan wbps_checker u_wbps_checker (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_found        (rsp_found),
   .rsp_match_offset (rsp_match_offset)
);

// ===== test/tb_top.sv =====
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import wbps_pkg::*;

   localparam int ITEM_TARGET = 1600;
   localparam int HOLD_CYCLES = 400;
   localparam int TAIL_ITEMS  = 250;

   typedef enum logic [1:0] {OUT_PREDICTED, OUT_NONE, OUT_GIVEN} outcome_type;
   typedef enum logic {ROW_BYTE, ROW_WRITE} row_kind_type;

   typedef struct {
      row_kind_type            kind;
      logic [CSR_INDEX_W-1:0]  index;
      logic [CSR_DATA_W-1:0]   value;
      logic [7:0]              data;
      logic                    last;
      outcome_type             outcome;
      logic                    found;
      logic [OFFSET_OUT_W-1:0] offset;
   } step_row_type;

   logic                    clock            = 1'b0;
   logic                    reset            = 1'b1;
   logic                    req_valid        = 1'b0;
   logic                    req_stall;
   logic [7:0]              req_data_byte    = '0;
   logic                    req_last_byte    = 1'b0;
   logic                    rsp_valid;
   logic                    rsp_stall        = 1'b0;
   logic                    rsp_found;
   logic [OFFSET_OUT_W-1:0] rsp_match_offset;
   logic                    csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0]  csr_index        = '0;
   logic [CSR_DATA_W-1:0]   csr_write_data   = '0;

   // predictor state and its copy of the registers
   logic [63:0]         cfg_low;
   logic [63:0]         cfg_high;
   logic [CARE_W-1:0]   cfg_care;
   logic [LENGTH_W-1:0] cfg_length;
   logic [7:0]          scan_window [16];
   logic [31:0]         scan_count;
   bit                  scan_matched;

   result_type  pending_matches [$];
   result_type  oldest;
   result_type  queued;
   logic        next_found;
   logic [31:0] next_offset;
   bit          next_hit;

   // what the sender attaches to the byte on offer
   outcome_type             byte_outcome = OUT_PREDICTED;
   logic                    given_found  = 1'b0;
   logic [OFFSET_OUT_W-1:0] given_offset = '0;

   int unsigned bytes_taken    = 0;
   int unsigned items_counted  = 0;
   int unsigned mismatch_count = 0;
   bit          quiet_tail     = 1'b0;
   bit          hold_off_req   = 1'b0;
   int          sender_calm    = 0;

   step_row_type directed_rows [$];

   wildcard_byte_pattern_scan i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_found        (rsp_found),
      .rsp_match_offset (rsp_match_offset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #4 clock = ~clock;

   function automatic logic [7:0] pattern_byte(input int i);
      if (i < 8) return cfg_low[8*i +: 8];
      return cfg_high[8*(i-8) +: 8];
   endfunction

   function automatic int effective_length();
      int n;
      n = cfg_length;
      if (n == 0) n = 1;
      if (n > 16) n = 16;
      return n;
   endfunction

   function automatic void rearm_scan();
      foreach (scan_window[k]) scan_window[k] = '0;
      scan_count   = '0;
      scan_matched = 1'b0;
   endfunction

   function automatic bit window_hit(input int len);
      for (int i = 0; i < len; i++) begin
         if (cfg_care[i] && scan_window[len-1-i] != pattern_byte(i)) return 1'b0;
      end
      return 1'b1;
   endfunction

   // one byte through the scanner, returns 1 when it gives a result
   function automatic bit scan_byte(input logic [7:0] data, input logic last,
                                    output logic hit, output logic [31:0] offset);
      int len;
      len    = effective_length();
      hit    = 1'b0;
      offset = '0;
      if (scan_matched) begin
         if (last) rearm_scan();
         return 1'b0;
      end
      if (scan_count != 32'hFFFF_FFFF) begin
         for (int k = 15; k > 0; k--) scan_window[k] = scan_window[k-1];
         scan_window[0] = data;
         scan_count++;
         if (scan_count >= len && window_hit(len)) begin
            hit    = 1'b1;
            offset = scan_count - len;
            if (last) rearm_scan();
            else scan_matched = 1'b1;
            return 1'b1;
         end
      end
      if (last) begin
         rearm_scan();
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic step_row_type byte_row(input logic [7:0] data, input logic last,
                                             input outcome_type outcome, input logic found,
                                             input logic [31:0] offset);
      step_row_type r;
      r.kind    = ROW_BYTE;
      r.index   = '0;
      r.value   = '0;
      r.data    = data;
      r.last    = last;
      r.outcome = outcome;
      r.found   = found;
      r.offset  = offset;
      return r;
   endfunction

   function automatic step_row_type write_row(input logic [CSR_INDEX_W-1:0] index,
                                              input logic [63:0] value);
      step_row_type r;
      r         = byte_row(8'h00, 1'b0, OUT_NONE, 1'b0, '0);
      r.kind    = ROW_WRITE;
      r.index   = index;
      r.value   = value;
      return r;
   endfunction

   // scoreboard, predictor and register mirror, all on the rising edge
   always @(posedge clock) begin
      if (reset) begin
         cfg_low    = '0;
         cfg_high   = '0;
         cfg_care   = CARE_MASK_RESET;
         cfg_length = LENGTH_RESET;
         rearm_scan();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_matches.size() == 0) begin
               $error("unexpected result: found %0d, match_offset %0d",
                      rsp_found, rsp_match_offset);
               mismatch_count++;
            end else begin
               oldest = pending_matches.pop_front();
               if (rsp_found !== oldest.found) begin
                  $error("found: expected %0d, actual %0d", oldest.found, rsp_found);
                  mismatch_count++;
               end
               if (rsp_match_offset !== oldest.match_offset) begin
                  $error("match_offset: expected %0d, actual %0d",
                         oldest.match_offset, rsp_match_offset);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            items_counted++;
            next_hit = scan_byte(req_data_byte, req_last_byte, next_found, next_offset);
            if (byte_outcome == OUT_GIVEN) begin
               queued.found        = given_found;
               queued.match_offset = given_offset;
               pending_matches.push_back(queued);
            end else if (byte_outcome == OUT_PREDICTED && next_hit) begin
               queued.found        = next_found;
               queued.match_offset = next_offset;
               pending_matches.push_back(queued);
            end
            bytes_taken++;
         end
         if (csr_write_enable) begin
            case (csr_index)
               CSR_PATTERN_LOW:  cfg_low    = csr_write_data;
               CSR_PATTERN_HIGH: cfg_high   = csr_write_data;
               CSR_CARE_MASK:    cfg_care   = csr_write_data[CARE_W-1:0];
               CSR_LENGTH:       cfg_length = csr_write_data[LENGTH_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // result side stall: random bursts, calm stretches, one long hold-off
   initial begin
      int calm;
      calm = 0;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_stall    = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_stall = 1'b0;
         end else if (quiet_tail || calm > 0) begin
            rsp_stall = 1'b0;
            if (calm > 0) calm--;
         end else if ($urandom_range(0, 39) == 0) begin
            rsp_stall = 1'b0;
            calm      = $urandom_range(30, 150);
         end else if ($urandom_range(0, 4) == 0) begin
            rsp_stall = 1'b1;
            repeat ($urandom_range(1, 19)) @(negedge clock);
            rsp_stall = 1'b0;
         end else begin
            rsp_stall = 1'b0;
         end
      end
   end

   // called on a falling edge, returns on a falling edge after the transfer
   task automatic offer_byte(input logic [7:0] data, input logic last,
                             input outcome_type outcome, input logic found,
                             input logic [31:0] offset);
      int unsigned target;
      target        = bytes_taken + 1;
      req_data_byte = data;
      req_last_byte = last;
      byte_outcome  = outcome;
      given_found   = found;
      given_offset  = offset;
      req_valid     = 1'b1;
      do @(negedge clock); while (bytes_taken != target);
      if (quiet_tail) return;
      if (sender_calm > 0) begin
         sender_calm--;
      end else if ($urandom_range(0, 49) == 0) begin
         sender_calm = $urandom_range(30, 150);
      end else if ($urandom_range(0, 5) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
   endtask

   task automatic wait_idle();
      req_valid = 1'b0;
      while (pending_matches.size() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index, input logic [63:0] value);
      csr_index        = index;
      csr_write_data   = value;
      csr_write_enable = 1'b1;
      @(negedge clock);
      csr_write_enable = 1'b0;
      @(negedge clock);
   endtask

   task automatic pick_setting();
      logic [63:0] v;
      case ($urandom_range(0, 5))
         0: begin
            write_reg(CSR_PATTERN_LOW, '0);
            write_reg(CSR_PATTERN_HIGH, '0);
         end
         1: begin
            write_reg(CSR_PATTERN_LOW, '1);
            write_reg(CSR_PATTERN_HIGH, '1);
         end
         default: begin
            write_reg(CSR_PATTERN_LOW, {$urandom, $urandom});
            write_reg(CSR_PATTERN_HIGH, {$urandom, $urandom});
         end
      endcase
      v = {$urandom, $urandom};
      case ($urandom_range(0, 5))
         0: v[15:0] = 16'h0000;
         1: v[15:0] = 16'hFFFF;
         2: v[15:0] = 16'($urandom & $urandom);
         3: v[15:0] = 16'($urandom | $urandom);
         default: v[15:0] = 16'($urandom);
      endcase
      write_reg(CSR_CARE_MASK, v);
      v = {$urandom, $urandom};
      case ($urandom_range(0, 7))
         0: v[4:0] = 5'd0;
         1: v[4:0] = 5'd1;
         2: v[4:0] = 5'd16;
         3: v[4:0] = 5'($urandom_range(17, 31));
         default: v[4:0] = 5'($urandom_range(1, 16));
      endcase
      write_reg(CSR_LENGTH, v);
   endtask

   // one scanned range: mostly the pattern with random wildcard content,
   // some near misses, pattern-flavored noise and plain noise
   task automatic send_range();
      logic [7:0] stream [$];
      int         len;
      int         style;
      int         prefix;
      int         flip;
      bit         close;
      len    = effective_length();
      style  = $urandom_range(0, 9);
      prefix = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 20) : $urandom_range(0, 4);
      close  = ($urandom_range(0, 29) != 0);
      repeat (prefix) begin
         if (style < 6 && $urandom_range(0, 1) == 0)
            stream.push_back(pattern_byte($urandom_range(0, len - 1)));
         else
            stream.push_back(8'($urandom_range(0, 255)));
      end
      if (style < 8) begin
         for (int i = 0; i < len; i++)
            stream.push_back(cfg_care[i] ? pattern_byte(i) : 8'($urandom_range(0, 255)));
         if (style >= 5) begin
            flip = $urandom_range(0, len - 1);
            stream[prefix + flip] = stream[prefix + flip] ^ 8'($urandom_range(1, 255));
         end
      end else begin
         repeat ($urandom_range(1, 20)) stream.push_back(8'($urandom_range(0, 255)));
      end
      repeat ($urandom_range(0, 6)) stream.push_back(8'($urandom_range(0, 255)));
      foreach (stream[i])
         offer_byte(stream[i], close && i == stream.size() - 1, OUT_PREDICTED, 1'b0, '0);
   endtask

   initial begin
      #8_000_000;
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      step_row_type row;
      int           phase;
      int           guard;

      // after reset: pattern zero, length one, full care
      directed_rows.push_back(byte_row(8'h00, 1'b0, OUT_GIVEN, 1'b1, 0));
      directed_rows.push_back(byte_row(8'hFF, 1'b0, OUT_NONE, 1'b0, 0));
      directed_rows.push_back(byte_row(8'h00, 1'b1, OUT_NONE, 1'b0, 0));
      directed_rows.push_back(byte_row(8'hFF, 1'b1, OUT_GIVEN, 1'b0, 0));
      // four byte pattern, third byte wildcard, overlapping start
      directed_rows.push_back(write_row(CSR_PATTERN_LOW, 64'h0000_0000_EFBE_ADDE));
      directed_rows.push_back(write_row(CSR_CARE_MASK, 64'hFFFB));
      directed_rows.push_back(write_row(CSR_LENGTH, 64'd4));
      directed_rows.push_back(byte_row(8'hDE, 1'b0, OUT_PREDICTED, 1'b0, 0));
      directed_rows.push_back(byte_row(8'hDE, 1'b0, OUT_PREDICTED, 1'b0, 0));
      directed_rows.push_back(byte_row(8'hAD, 1'b0, OUT_PREDICTED, 1'b0, 0));
      directed_rows.push_back(byte_row(8'h00, 1'b0, OUT_PREDICTED, 1'b0, 0));
      directed_rows.push_back(byte_row(8'hEF, 1'b0, OUT_GIVEN, 1'b1, 1));
      directed_rows.push_back(byte_row(8'h55, 1'b1, OUT_NONE, 1'b0, 0));
      // range shorter than the pattern
      directed_rows.push_back(byte_row(8'hDE, 1'b0, OUT_PREDICTED, 1'b0, 0));
      directed_rows.push_back(byte_row(8'hAD, 1'b1, OUT_GIVEN, 1'b0, 0));
      // length zero acts as one, all wildcards
      directed_rows.push_back(write_row(CSR_LENGTH, 64'd0));
      directed_rows.push_back(write_row(CSR_CARE_MASK, 64'h0));
      directed_rows.push_back(byte_row(8'h12, 1'b0, OUT_GIVEN, 1'b1, 0));
      directed_rows.push_back(byte_row(8'h34, 1'b1, OUT_NONE, 1'b0, 0));
      // oversized length clamps to sixteen
      directed_rows.push_back(write_row(CSR_LENGTH, 64'd31));
      directed_rows.push_back(byte_row(8'hA0, 1'b0, OUT_PREDICTED, 1'b0, 0));
      directed_rows.push_back(byte_row(8'hA1, 1'b0, OUT_PREDICTED, 1'b0, 0));
      directed_rows.push_back(byte_row(8'hA2, 1'b1, OUT_GIVEN, 1'b0, 0));
      // all-ones pattern, match on the last byte
      directed_rows.push_back(write_row(CSR_PATTERN_LOW, '1));
      directed_rows.push_back(write_row(CSR_PATTERN_HIGH, '1));
      directed_rows.push_back(write_row(CSR_CARE_MASK, 64'hFFFF));
      directed_rows.push_back(write_row(CSR_LENGTH, 64'd2));
      directed_rows.push_back(byte_row(8'hFF, 1'b0, OUT_PREDICTED, 1'b0, 0));
      directed_rows.push_back(byte_row(8'hFF, 1'b1, OUT_GIVEN, 1'b1, 0));
      directed_rows.push_back(byte_row(8'h00, 1'b1, OUT_GIVEN, 1'b0, 0));

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      foreach (directed_rows[r]) begin
         row = directed_rows[r];
         if (row.kind == ROW_WRITE) begin
            wait_idle();
            write_reg(row.index, row.value);
         end else begin
            offer_byte(row.data, row.last, row.outcome, row.found, row.offset);
         end
      end

      phase = 0;
      while (items_counted < ITEM_TARGET) begin
         if (items_counted + TAIL_ITEMS >= ITEM_TARGET) begin
            // last stretch: no gaps on either side, setting left as it is
            quiet_tail = 1'b1;
            send_range();
         end else begin
            wait_idle();
            if (phase == 2) begin
               // every range matches on its first byte so the result side backs up
               write_reg(CSR_CARE_MASK, 64'h0);
               write_reg(CSR_LENGTH, 64'd1);
               hold_off_req = 1'b1;
               repeat (40) send_range();
            end else begin
               pick_setting();
               repeat ($urandom_range(3, 15)) send_range();
            end
            phase++;
         end
      end

      quiet_tail = 1'b1;
      req_valid  = 1'b0;
      guard      = 0;
      while (pending_matches.size() != 0 && guard < 2000) begin
         @(negedge clock);
         guard++;
      end
      repeat (8) @(negedge clock);
      if (pending_matches.size() != 0) begin
         $error("%0d expected results never arrived", pending_matches.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
